// ===== design/i2c_master_write_read_sequencer_top_assert.svh =====
// Assertion macros for the I2C write/read sequencer checker.
// Needs nothing else; included by the checker file only.
`ifndef I2C_MASTER_WRITE_READ_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_WRITE_READ_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define I2CMWR_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("sequencer assertion failed");

// Next-cycle implication, disabled while rst is high.
`define I2CMWR_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("sequencer assertion failed");

`endif

// ===== design/i2cmwr_pkg.sv =====
// Types, codes and constants shared by the I2C write/read sequencer.
// No dependencies.
`timescale 1ns / 1ps

package i2cmwr_pkg;

   localparam int LENGTH_BITS = 16;

   localparam logic [2:0] OP_BEGIN   = 3'd0;
   localparam logic [2:0] OP_STATUS  = 3'd1;
   localparam logic [2:0] OP_ERROR   = 3'd2;
   localparam logic [2:0] OP_WR_DONE = 3'd3;
   localparam logic [2:0] OP_WR_ERR  = 3'd4;
   localparam logic [2:0] OP_RD_DONE = 3'd5;
   localparam logic [2:0] OP_RD_ERR  = 3'd6;
   localparam logic [2:0] OP_HALF    = 3'd7;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_ADDR   = 3'd2;
   localparam logic [2:0] ACT_DMA_WR = 3'd3;
   localparam logic [2:0] ACT_DMA_RD = 3'd4;
   localparam logic [2:0] ACT_STOP   = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_WRITE_ERR = 2'd1;
   localparam logic [1:0] ST_READ_ERR  = 2'd2;
   localparam logic [1:0] ST_NO_ACK    = 2'd3;

   localparam int FLAG_SB      = 0;
   localparam int FLAG_ADDR    = 1;
   localparam int FLAG_BTF     = 2;
   localparam int FLAG_NACK    = 3;
   localparam int FLAG_OVERRUN = 4;
   localparam int FLAG_ARLO    = 5;
   localparam int FLAG_BERR    = 6;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [6:0]  device_address;
      logic [15:0] write_length;
      logic [15:0] read_length;
      logic [6:0]  status_flags;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  address_byte;
      logic [15:0] transfer_length;
      logic        ack_enable;
      logic        stop_dma;
      logic        done_res;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [6:0]             target_address;
      logic [LENGTH_BITS-1:0] pending_write;
      logic [LENGTH_BITS-1:0] pending_read;
   } seq_state_type;

endpackage

// ===== design/i2cmwr_state.sv =====
// Transaction state registers: target address and pending byte counts.
// Depends on i2cmwr_pkg.
`timescale 1ns / 1ps

module i2cmwr_state (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      update,
   input  i2cmwr_pkg::seq_state_type state_in,
   output i2cmwr_pkg::seq_state_type state_ff
);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/i2cmwr_decide.sv =====
// Per-event decision logic: result fields and next transaction state.
// Depends on i2cmwr_pkg.
`timescale 1ns / 1ps

module i2cmwr_decide (
   input  i2cmwr_pkg::req_type       req,
   input  i2cmwr_pkg::seq_state_type cur,
   output i2cmwr_pkg::rsp_type       rsp,
   output i2cmwr_pkg::seq_state_type nxt
);

   logic wr_pending;
   logic rd_pending;

   assign wr_pending = (cur.pending_write != '0);
   assign rd_pending = (cur.pending_read != '0);

   always_comb begin
      rsp = '0;
      nxt = cur;
      unique case (req.opcode)
         i2cmwr_pkg::OP_BEGIN: begin
            nxt.target_address = req.device_address;
            nxt.pending_write  = i2cmwr_pkg::LENGTH_BITS'(req.write_length);
            nxt.pending_read   = i2cmwr_pkg::LENGTH_BITS'(req.read_length);
            rsp.action         = i2cmwr_pkg::ACT_START;
         end
         i2cmwr_pkg::OP_STATUS: begin
            // SB outranks ADDR; BTF alone leaves the bus untouched.
            if (req.status_flags[i2cmwr_pkg::FLAG_SB]) begin
               rsp.action       = i2cmwr_pkg::ACT_ADDR;
               rsp.address_byte = {cur.target_address, !wr_pending};
            end else if (req.status_flags[i2cmwr_pkg::FLAG_ADDR]) begin
               if (wr_pending) begin
                  rsp.action          = i2cmwr_pkg::ACT_DMA_WR;
                  rsp.transfer_length = 16'(cur.pending_write);
               end else if (rd_pending) begin
                  rsp.action          = i2cmwr_pkg::ACT_DMA_RD;
                  rsp.transfer_length = 16'(cur.pending_read);
                  rsp.ack_enable      =
                     (cur.pending_read > i2cmwr_pkg::LENGTH_BITS'(1));
               end
            end
         end
         i2cmwr_pkg::OP_ERROR: begin
            if (req.status_flags[i2cmwr_pkg::FLAG_NACK] ||
                req.status_flags[i2cmwr_pkg::FLAG_OVERRUN] ||
                req.status_flags[i2cmwr_pkg::FLAG_ARLO] ||
                req.status_flags[i2cmwr_pkg::FLAG_BERR]) begin
               nxt.pending_write = '0;
               nxt.pending_read  = '0;
               rsp.action        = i2cmwr_pkg::ACT_STOP;
               rsp.stop_dma      = 1'b1;
               rsp.done_res      = 1'b1;
            end
            priority if (req.status_flags[i2cmwr_pkg::FLAG_NACK]) begin
               rsp.status = i2cmwr_pkg::ST_NO_ACK;
            end else if (req.status_flags[i2cmwr_pkg::FLAG_OVERRUN]) begin
               rsp.status = i2cmwr_pkg::ST_READ_ERR;
            end else if (req.status_flags[i2cmwr_pkg::FLAG_ARLO] ||
                         req.status_flags[i2cmwr_pkg::FLAG_BERR]) begin
               rsp.status = i2cmwr_pkg::ST_WRITE_ERR;
            end else begin
               rsp.status = i2cmwr_pkg::ST_OK;
            end
         end
         i2cmwr_pkg::OP_WR_DONE: begin
            nxt.pending_write = '0;
            // A pending read phase goes on with a repeated START.
            if (rd_pending) begin
               rsp.action = i2cmwr_pkg::ACT_START;
            end else begin
               rsp.action   = i2cmwr_pkg::ACT_STOP;
               rsp.done_res = 1'b1;
               rsp.status   = i2cmwr_pkg::ST_OK;
            end
         end
         i2cmwr_pkg::OP_WR_ERR, i2cmwr_pkg::OP_RD_ERR: begin
            nxt.pending_write = '0;
            nxt.pending_read  = '0;
            rsp.action        = i2cmwr_pkg::ACT_STOP;
            rsp.stop_dma      = 1'b1;
            rsp.done_res      = 1'b1;
            rsp.status        = (req.opcode == i2cmwr_pkg::OP_WR_ERR) ?
                                i2cmwr_pkg::ST_WRITE_ERR : i2cmwr_pkg::ST_READ_ERR;
         end
         i2cmwr_pkg::OP_RD_DONE: begin
            nxt.pending_read = '0;
            rsp.action       = i2cmwr_pkg::ACT_STOP;
            rsp.done_res     = 1'b1;
            rsp.status       = i2cmwr_pkg::ST_OK;
         end
         i2cmwr_pkg::OP_HALF: begin
            rsp = '0;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

// ===== design/i2c_master_write_read_sequencer_top.sv =====
// Top level of the I2C master write-then-read sequencer.
// Depends on i2cmwr_pkg, i2cmwr_state and i2cmwr_decide.
//
// Usage:
// - req_valid/req_stall/req_data carry one event request (begin, status,
//   error, DMA done/error, half-complete). Every request yields exactly one
//   response on rsp_valid/rsp_stall/rsp_data.
// - A request is taken into an input register, decided by one pass of
//   combinational logic against the transaction state, and the response is
//   held in an output register. Throughput is one request per cycle while
//   rsp_stall does not hold a waiting response in the output register.
// - The transaction state is updated in the same cycle the request moves
//   into the output register, so requests are decided strictly in order.
// - When rsp_stall is high with a response waiting, the input register
//   holds its request and req_stall rises; nothing is dropped and at most
//   two requests sit inside the block.
// - reset (synchronous, active high) empties both registers and clears the
//   target address and the pending byte counts.
`timescale 1ns / 1ps

module i2c_master_write_read_sequencer_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2cmwr_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cmwr_pkg::rsp_type rsp_data
);

   logic                      in_valid_ff;
   i2cmwr_pkg::req_type       in_data_ff;
   logic                      rsp_valid_ff;
   i2cmwr_pkg::rsp_type       rsp_data_ff;
   i2cmwr_pkg::rsp_type       rsp_data_in;
   i2cmwr_pkg::seq_state_type state_ff;
   i2cmwr_pkg::seq_state_type state_in;
   logic                      out_open;
   logic                      advance;

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   i2cmwr_decide u_decide (
      .req (in_data_ff),
      .cur (state_ff),
      .rsp (rsp_data_in),
      .nxt (state_in)
   );

   i2cmwr_state u_state (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .state_in (state_in),
      .state_ff (state_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/i2cmwr_checker.sv =====
// Port-level checker for the I2C write/read sequencer, bound to the top.
// Depends on i2cmwr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_master_write_read_sequencer_top_assert.svh"

module i2cmwr_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input i2cmwr_pkg::rsp_type rsp_data
);

   logic req_seen;
   logic hold_seen;
   logic done_seen;
   logic abort_seen;
   logic stop_shown;
   logic code_shown;

   assign req_seen   = req_valid && !req_stall;
   assign hold_seen  = rsp_valid && rsp_stall;
   assign done_seen  = rsp_valid && rsp_data.done_res;
   assign abort_seen = rsp_valid && rsp_data.stop_dma;
   assign stop_shown = (rsp_data.action == i2cmwr_pkg::ACT_STOP);
   assign code_shown = rsp_data.done_res && (rsp_data.status != i2cmwr_pkg::ST_OK);

   // A held response must stay in place until it is taken.
   `I2CMWR_ASSERT_NEXT(a_rsp_hold, clock, reset, hold_seen, rsp_valid && $stable(rsp_data))
   `I2CMWR_ASSERT_IMPLIES(a_done_only_on_stop, clock, reset, done_seen, stop_shown)
   `I2CMWR_ASSERT_IMPLIES(a_abort_has_code, clock, reset, abort_seen, code_shown)
   `I2CMWR_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid && !req_stall)
   `I2CMWR_ASSERT_NEXT(a_accept_reaches_out, clock, reset, req_seen && !rsp_valid, ##1 rsp_valid)

endmodule

bind i2c_master_write_read_sequencer_top i2cmwr_checker u_i2cmwr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/i2c_master_write_read_sequencer_top_tb.sv =====
// Testbench for the I2C master write-then-read sequencer: a directed table, then
// random transactions checked against a cycle-free predictor of the decisions.
// Depends on i2cmwr_pkg and i2c_master_write_read_sequencer_top.
`timescale 1ns / 1ps

module i2c_master_write_read_sequencer_top_tb;

   localparam int RANDOM_REQUESTS = 1600;

   typedef struct {
      i2cmwr_pkg::req_type stim;
      bit                  typed;
      i2cmwr_pkg::rsp_type want;
   } table_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   i2cmwr_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   i2cmwr_pkg::rsp_type rsp_data;

   i2cmwr_pkg::seq_state_type txn_state;
   i2cmwr_pkg::rsp_type       pending_decisions[$];
   table_row_type             directed_rows[$];
   int                        failures;
   int                        random_sent;
   bit                        quiet;
   bit                        hold_off_request;

   i2c_master_write_read_sequencer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Works out the decision for one request and advances the transaction state.
   function automatic i2cmwr_pkg::rsp_type decide_event(input i2cmwr_pkg::req_type r);
      i2cmwr_pkg::rsp_type d;
      d = '0;
      case (r.opcode)
         i2cmwr_pkg::OP_BEGIN: begin
            txn_state.target_address = r.device_address;
            txn_state.pending_write = r.write_length;
            txn_state.pending_read = r.read_length;
            d.action = i2cmwr_pkg::ACT_START;
         end
         i2cmwr_pkg::OP_STATUS: begin
            if (r.status_flags[i2cmwr_pkg::FLAG_SB]) begin
               d.action = i2cmwr_pkg::ACT_ADDR;
               d.address_byte = {txn_state.target_address, txn_state.pending_write == '0};
            end else if (r.status_flags[i2cmwr_pkg::FLAG_ADDR]) begin
               if (txn_state.pending_write != '0) begin
                  d.action = i2cmwr_pkg::ACT_DMA_WR;
                  d.transfer_length = txn_state.pending_write[15:0];
               end else if (txn_state.pending_read != '0) begin
                  d.action = i2cmwr_pkg::ACT_DMA_RD;
                  d.transfer_length = txn_state.pending_read[15:0];
                  d.ack_enable = txn_state.pending_read > 1;
               end
            end
         end
         i2cmwr_pkg::OP_ERROR, i2cmwr_pkg::OP_WR_ERR, i2cmwr_pkg::OP_RD_ERR: begin
            d.status = i2cmwr_pkg::ST_WRITE_ERR;
            if (r.opcode == i2cmwr_pkg::OP_RD_ERR) begin
               d.status = i2cmwr_pkg::ST_READ_ERR;
            end
            if (r.opcode == i2cmwr_pkg::OP_ERROR) begin
               if (r.status_flags[i2cmwr_pkg::FLAG_NACK]) begin
                  d.status = i2cmwr_pkg::ST_NO_ACK;
               end else if (r.status_flags[i2cmwr_pkg::FLAG_OVERRUN]) begin
                  d.status = i2cmwr_pkg::ST_READ_ERR;
               end else if (!r.status_flags[i2cmwr_pkg::FLAG_ARLO] &&
                            !r.status_flags[i2cmwr_pkg::FLAG_BERR]) begin
                  // No error flag at all: nothing happens.
                  return '0;
               end
            end
            txn_state.pending_write = '0;
            txn_state.pending_read = '0;
            d.action = i2cmwr_pkg::ACT_STOP;
            d.stop_dma = 1'b1;
            d.done_res = 1'b1;
         end
         i2cmwr_pkg::OP_WR_DONE: begin
            txn_state.pending_write = '0;
            if (txn_state.pending_read != '0) begin
               d.action = i2cmwr_pkg::ACT_START;
            end else begin
               d.action = i2cmwr_pkg::ACT_STOP;
               d.done_res = 1'b1;
               d.status = i2cmwr_pkg::ST_OK;
            end
         end
         i2cmwr_pkg::OP_RD_DONE: begin
            txn_state.pending_read = '0;
            d.action = i2cmwr_pkg::ACT_STOP;
            d.done_res = 1'b1;
            d.status = i2cmwr_pkg::ST_OK;
         end
         default: begin
         end
      endcase
      return d;
   endfunction

   function automatic i2cmwr_pkg::req_type make_req(input logic [2:0] op,
                                                    input logic [6:0] addr,
                                                    input logic [15:0] wl,
                                                    input logic [15:0] rl,
                                                    input logic [6:0] flags);
      i2cmwr_pkg::req_type r;
      r.opcode = op;
      r.device_address = addr;
      r.write_length = wl;
      r.read_length = rl;
      r.status_flags = flags;
      return r;
   endfunction

   // Fields that the opcode ignores are filled with random bits.
   function automatic i2cmwr_pkg::req_type event_req(input logic [2:0] op,
                                                     input logic [6:0] flags);
      return make_req(op, 7'($urandom), 16'($urandom), 16'($urandom), flags);
   endfunction

   function automatic i2cmwr_pkg::rsp_type make_rsp(input logic [2:0] act,
                                                    input logic [7:0] abyte,
                                                    input logic [15:0] len,
                                                    input logic ack,
                                                    input logic sdma, input logic done,
                                                    input logic [1:0] st);
      i2cmwr_pkg::rsp_type d;
      d.action = act;
      d.address_byte = abyte;
      d.transfer_length = len;
      d.ack_enable = ack;
      d.stop_dma = sdma;
      d.done_res = done;
      d.status = st;
      return d;
   endfunction

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         3: return 16'hFFFF;
         4, 5, 6: return 16'($urandom_range(1, 16));
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one request, waits for it to be taken and files its expected decision.
   task automatic send_request(input i2cmwr_pkg::req_type r, input bit typed,
                               input i2cmwr_pkg::rsp_type want);
      int gap;
      i2cmwr_pkg::rsp_type predicted;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = decide_event(r);
      pending_decisions.push_back(typed ? want : predicted);
   endtask

   task automatic send_random(input i2cmwr_pkg::req_type r);
      send_request(r, 1'b0, '0);
      random_sent++;
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_decisions.size() != 0);
   endtask

   task automatic add_row(input i2cmwr_pkg::req_type r, input bit typed,
                          input i2cmwr_pkg::rsp_type want);
      table_row_type row;
      row.stim = r;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // One write-then-read transaction, sometimes with extra events or cut short by a fault.
   task automatic run_transaction();
      i2cmwr_pkg::req_type steps[$];
      logic [15:0] wl;
      logic [15:0] rl;
      int fault_at;
      wl = pick_length();
      rl = pick_length();
      steps.push_back(make_req(i2cmwr_pkg::OP_BEGIN, 7'($urandom), wl, rl, 7'($urandom)));
      steps.push_back(event_req(i2cmwr_pkg::OP_STATUS, $urandom_range(0, 3) == 0 ?
                                7'($urandom) | 7'h01 : 7'h01));
      steps.push_back(event_req(i2cmwr_pkg::OP_STATUS, $urandom_range(0, 3) == 0 ?
                                (7'($urandom) & 7'h7E) | 7'h02 : 7'h02));
      if ($urandom_range(0, 4) == 0) begin
         steps.push_back(event_req(i2cmwr_pkg::OP_HALF, 7'($urandom)));
      end
      if ($urandom_range(0, 4) == 0) begin
         steps.push_back(event_req(i2cmwr_pkg::OP_STATUS, (7'($urandom) & 7'h7C) | 7'h04));
      end
      if (wl != 0 || rl == 0) begin
         steps.push_back(event_req(i2cmwr_pkg::OP_WR_DONE, 7'($urandom)));
      end
      if (rl != 0) begin
         if (wl != 0) begin
            steps.push_back(event_req(i2cmwr_pkg::OP_STATUS, 7'h01));
            steps.push_back(event_req(i2cmwr_pkg::OP_STATUS, 7'h02));
         end
         steps.push_back(event_req(i2cmwr_pkg::OP_RD_DONE, 7'($urandom)));
      end
      if ($urandom_range(0, 6) == 0) begin
         fault_at = $urandom_range(1, steps.size() - 1);
         while (steps.size() > fault_at) begin
            void'(steps.pop_back());
         end
         case ($urandom_range(0, 2))
            0: steps.push_back(event_req(i2cmwr_pkg::OP_WR_ERR, 7'($urandom)));
            1: steps.push_back(event_req(i2cmwr_pkg::OP_RD_ERR, 7'($urandom)));
            default: steps.push_back(event_req(i2cmwr_pkg::OP_ERROR, 7'($urandom)));
         endcase
      end
      foreach (steps[i]) begin
         send_random(steps[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      i2cmwr_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_decisions.size() == 0) begin
            $error("response with no request outstanding: %0h", rsp_data);
            failures++;
         end else begin
            want = pending_decisions.pop_front();
            check_field("action", 16'(want.action), 16'(rsp_data.action));
            check_field("address_byte", 16'(want.address_byte), 16'(rsp_data.address_byte));
            check_field("transfer_length", want.transfer_length, rsp_data.transfer_length);
            check_field("ack_enable", 16'(want.ack_enable), 16'(rsp_data.ack_enable));
            check_field("stop_dma", 16'(want.stop_dma), 16'(rsp_data.stop_dma));
            check_field("done_res", 16'(want.done_res), 16'(rsp_data.done_res));
            check_field("status", 16'(want.status), 16'(rsp_data.status));
         end
      end
   end

   // Response side: random bursts of stall, plus one long hold-off on request.
   initial begin
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = 80;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b0;
            run_left--;
         end else begin
            rsp_stall <= 1'b0;
            run_left = quiet ? 16 : $urandom_range(0, 12);
            stall_left = idle_length();
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      failures = 0;
      random_sent = 0;
      quiet = 1'b0;
      hold_off_request = 1'b0;
      txn_state = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;

      // After reset: address zero, nothing pending.
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h01), 1,
              make_rsp(i2cmwr_pkg::ACT_ADDR, 8'h01, 0, 0, 0, 0, i2cmwr_pkg::ST_OK));
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h02), 1, '0);
      add_row(make_req(i2cmwr_pkg::OP_BEGIN, 7'h7F, 16'hFFFF, 16'hFFFF, 7'h7F), 1,
              make_rsp(i2cmwr_pkg::ACT_START, 0, 0, 0, 0, 0, i2cmwr_pkg::ST_OK));
      // SB wins over every other flag; R/W is low with a write pending.
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h7F), 1,
              make_rsp(i2cmwr_pkg::ACT_ADDR, 8'hFE, 0, 0, 0, 0, i2cmwr_pkg::ST_OK));
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h06), 1,
              make_rsp(i2cmwr_pkg::ACT_DMA_WR, 0, 16'hFFFF, 0, 0, 0, i2cmwr_pkg::ST_OK));
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h04), 1, '0);
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h00), 1, '0);
      add_row(event_req(i2cmwr_pkg::OP_HALF, 7'h7F), 1, '0);
      add_row(event_req(i2cmwr_pkg::OP_WR_DONE, 7'h00), 1,
              make_rsp(i2cmwr_pkg::ACT_START, 0, 0, 0, 0, 0, i2cmwr_pkg::ST_OK));
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h7E), 1,
              make_rsp(i2cmwr_pkg::ACT_DMA_RD, 0, 16'hFFFF, 1, 0, 0, i2cmwr_pkg::ST_OK));
      add_row(event_req(i2cmwr_pkg::OP_RD_DONE, 7'h00), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 0, 1, i2cmwr_pkg::ST_OK));
      add_row(make_req(i2cmwr_pkg::OP_BEGIN, 7'h00, 16'h0000, 16'h0001, 7'h00), 0, '0);
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h01), 0, '0);
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h02), 1,
              make_rsp(i2cmwr_pkg::ACT_DMA_RD, 0, 16'd1, 0, 0, 0, i2cmwr_pkg::ST_OK));
      // Error priority: no acknowledge, then overrun, then arbitration lost or bus error.
      add_row(event_req(i2cmwr_pkg::OP_ERROR, 7'h7F), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 1, 1, i2cmwr_pkg::ST_NO_ACK));
      add_row(make_req(i2cmwr_pkg::OP_BEGIN, 7'h55, 16'h0002, 16'h0000, 7'h00), 0, '0);
      add_row(event_req(i2cmwr_pkg::OP_STATUS, 7'h01), 0, '0);
      add_row(event_req(i2cmwr_pkg::OP_ERROR, 7'h70), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 1, 1, i2cmwr_pkg::ST_READ_ERR));
      add_row(event_req(i2cmwr_pkg::OP_ERROR, 7'h60), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 1, 1, i2cmwr_pkg::ST_WRITE_ERR));
      add_row(event_req(i2cmwr_pkg::OP_ERROR, 7'h40), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 1, 1, i2cmwr_pkg::ST_WRITE_ERR));
      add_row(event_req(i2cmwr_pkg::OP_ERROR, 7'h07), 1, '0);
      // Both lengths zero still asks for a START; write done then finishes.
      add_row(make_req(i2cmwr_pkg::OP_BEGIN, 7'h2A, 16'h0000, 16'h0000, 7'h00), 0, '0);
      add_row(event_req(i2cmwr_pkg::OP_WR_DONE, 7'h00), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 0, 1, i2cmwr_pkg::ST_OK));
      add_row(event_req(i2cmwr_pkg::OP_WR_ERR, 7'h00), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 1, 1, i2cmwr_pkg::ST_WRITE_ERR));
      add_row(event_req(i2cmwr_pkg::OP_RD_ERR, 7'h00), 1,
              make_rsp(i2cmwr_pkg::ACT_STOP, 0, 0, 0, 1, 1, i2cmwr_pkg::ST_READ_ERR));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
      end
      wait_all_answered();

      while (random_sent < RANDOM_REQUESTS) begin
         if (random_sent >= 400 && random_sent < 480) begin
            // Back-to-back traffic against a long response hold-off fills the block.
            if (!quiet) begin
               hold_off_request = 1'b1;
            end
            quiet = 1'b1;
         end else if (random_sent >= 900 && random_sent < 1000) begin
            quiet = 1'b1;
         end else begin
            quiet = 1'b0;
         end
         if (random_sent >= 1200 && random_sent < 1210) begin
            wait_all_answered();
         end
         if ($urandom_range(0, 6) == 0) begin
            send_random(make_req(3'($urandom), 7'($urandom), 16'($urandom),
                                 16'($urandom), 7'($urandom)));
         end else begin
            run_transaction();
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (pending_decisions.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
